/* rtl/core/cdm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types of the CPPM decoder with median-of-three filtering.
package cdm_pkg;

  // Sizes of the channel history.
  localparam int unsigned MaxChannels = 16;
  localparam int unsigned ChanW       = $clog2(MaxChannels);
  localparam int unsigned CntW        = $clog2(MaxChannels + 1);
  localparam int unsigned HistDepth   = 3;
  localparam int unsigned SlotW       = $clog2(HistDepth);

  // Field widths.
  localparam int unsigned ValW     = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ChCfgW   = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register reset values.
  localparam logic [ChCfgW-1:0] RstChanCount = ChCfgW'(8);
  localparam logic [ValW-1:0]   RstMinWidth  = ValW'(1000);
  localparam logic [ValW-1:0]   RstMaxWidth  = ValW'(2000);
  localparam logic [ValW-1:0]   RstDefault   = ValW'(1500);
  localparam logic [ValW-1:0]   RstSyncThr   = ValW'(3000);
  localparam logic [ValW-1:0]   RstTimeout   = ValW'(100);

  // History entries that were never written read as the reset default.
  localparam logic [ValW-1:0] HistResetVal = RstDefault;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChanCount = 3'd0,
    CfgMinWidth  = 3'd1,
    CfgMaxWidth  = 3'd2,
    CfgDefault   = 3'd3,
    CfgSyncThr   = 3'd4,
    CfgTimeout   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OpEdge = 1'b0,
    OpRead = 1'b1
  } op_e;

  typedef struct packed {
    logic [ChCfgW-1:0] chan_count;
    logic [ValW-1:0]   min_width;
    logic [ValW-1:0]   max_width;
    logic [ValW-1:0]   default_val;
    logic [ValW-1:0]   sync_thr;
    logic [ValW-1:0]   timeout;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [ChanW-1:0] chan;
    logic [ValW-1:0]  value;
  } hist_wr_t;

endpackage

/* rtl/core/cdm_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the decoder's input and result words.
interface cdm_in_if;
  import cdm_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [TimeW-1:0] time_us;
  logic [TimeW-1:0] time_ms;
  logic [ChanW-1:0] channel;

  modport source (output valid, output operation, output time_us, output time_ms,
                  output channel, input ready);
  modport sink   (input valid, input operation, input time_us, input time_ms,
                  input channel, output ready);
endinterface

interface cdm_out_if;
  import cdm_pkg::*;
  logic             valid;
  logic             ready;
  logic [ValW-1:0]  value;
  logic             receiving;
  logic [TimeW-1:0] ms_since_frame;

  modport source (output valid, output value, output receiving, output ms_since_frame,
                  input ready);
  modport sink   (input valid, input value, input receiving, input ms_since_frame,
                  output ready);
endinterface

/* rtl/core/cdm_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register file written through a plain write port.
module cdm_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [cdm_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [cdm_pkg::CfgDataW-1:0] wdata_i,
  output cdm_pkg::cfg_t                cfg_o
);
  import cdm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chan_count  <= RstChanCount;
      cfg_q.min_width   <= RstMinWidth;
      cfg_q.max_width   <= RstMaxWidth;
      cfg_q.default_val <= RstDefault;
      cfg_q.sync_thr    <= RstSyncThr;
      cfg_q.timeout     <= RstTimeout;
    end else if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CfgChanCount: cfg_q.chan_count  <= wdata_i[ChCfgW-1:0];
        CfgMinWidth:  cfg_q.min_width   <= wdata_i;
        CfgMaxWidth:  cfg_q.max_width   <= wdata_i;
        CfgDefault:   cfg_q.default_val <= wdata_i;
        CfgSyncThr:   cfg_q.sync_thr    <= wdata_i;
        CfgTimeout:   cfg_q.timeout     <= wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/cdm_history.sv */
`timescale 1ns / 1ps
// Per-channel three-deep history rings with a median-of-three read.
module cdm_history (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cdm_pkg::hist_wr_t          wr_i,
  input  logic [cdm_pkg::ChanW-1:0]  rd_chan_i,
  output logic [cdm_pkg::ValW-1:0]   median_o
);
  import cdm_pkg::*;

  // One bank per ring position; each bank is read at a single channel.
  logic [ValW-1:0]        bank_q  [HistDepth][MaxChannels];
  logic [MaxChannels-1:0] valid_q [HistDepth];
  logic [SlotW-1:0]       slot_q  [MaxChannels];

  logic [SlotW-1:0] wr_slot;
  logic [SlotW-1:0] next_slot;
  logic [ValW-1:0]  rd_val [HistDepth];
  logic [ValW-1:0]  lo, hi;

  always_comb begin
    wr_slot = slot_q[wr_i.chan];
    if (wr_slot >= SlotW'(HistDepth)) begin
      wr_slot = '0;
    end
    next_slot = wr_slot + SlotW'(1);
    if (next_slot >= SlotW'(HistDepth)) begin
      next_slot = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MaxChannels; c++) begin
        slot_q[c] <= '0;
      end
    end else if (wr_i.en) begin
      slot_q[wr_i.chan] <= next_slot;
    end
  end

  for (genvar b = 0; b < HistDepth; b++) begin : g_bank
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[b] <= '0;
      end else if (wr_i.en && (wr_slot == SlotW'(b))) begin
        valid_q[b][wr_i.chan] <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_slot == SlotW'(b))) begin
        bank_q[b][wr_i.chan] <= wr_i.value;
      end
    end

    assign rd_val[b] = valid_q[b][rd_chan_i] ? bank_q[b][rd_chan_i] : HistResetVal;
  end

  always_comb begin
    lo = (rd_val[0] < rd_val[1]) ? rd_val[0] : rd_val[1];
    hi = (rd_val[0] < rd_val[1]) ? rd_val[1] : rd_val[0];
    if (rd_val[2] <= lo) begin
      median_o = lo;
    end else if (rd_val[2] >= hi) begin
      median_o = hi;
    end else begin
      median_o = rd_val[2];
    end
  end

endmodule

/* rtl/core/cppm_decoder_median3.sv */
`timescale 1ns / 1ps
// Top level of the CPPM pulse position decoder with median-of-three channel filtering.
//
// Usage: every input word is either a falling-edge event of the PPM line
// (operation 0, stamped with wrapping microsecond and millisecond times) or a
// channel read (operation 1). Each input word produces exactly one result word
// with the filtered channel value (zero for edges), the receiving flag and the
// milliseconds elapsed since the last frame sync.
// Both channels use valid/ready; a word moves when both are high at a clock edge.
// The input word is registered, decoded in the following cycle against the frame
// state and the history rings, and the result is registered. When the result
// register is free, a result word becomes valid at the clock edge after its input
// word was taken, and one word per cycle is sustained while the receiver does not
// stall; the single decode stage between the two registers sets that rate.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while the block
// is idle. Reset (rst_ni low, asynchronous) loads the register defaults, clears
// the frame state and marks all history entries unwritten so that they read as
// the reset default of 1500; no clearing pass is needed.
// When the receiver stalls, the result word holds, at most one more input word is taken
// into the input register, and ready then drops until the result is taken.
module cppm_decoder_median3 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cdm_in_if.sink                       in_i,
  cdm_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [cdm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cdm_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import cdm_pkg::*;

  cfg_t cfg;

  // Input register.
  logic             s1_valid_q;
  logic             s1_op_q;
  logic [TimeW-1:0] s1_tus_q;
  logic [TimeW-1:0] s1_tms_q;
  logic [ChanW-1:0] s1_ch_q;

  // Result register.
  logic             out_valid_q;
  logic [ValW-1:0]  out_value_q;
  logic             out_recv_q;
  logic [TimeW-1:0] out_msf_q;

  // Frame state.
  logic [TimeW-1:0] last_edge_q, last_edge_d;
  logic [TimeW-1:0] last_frame_q, last_frame_d;
  logic [CntW-1:0]  chan_cnt_q, chan_cnt_d;
  logic             recv_q, recv_d;

  logic             out_free;
  logic             s1_fire;
  logic             in_fire;
  logic [CntW-1:0]  n_eff;
  logic [TimeW-1:0] width;
  logic             is_sync;
  logic [ValW-1:0]  clamped;
  logic             timed_out;
  hist_wr_t         hist_wr;
  logic [ValW-1:0]  median;
  logic [ValW-1:0]  read_val;

  cdm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Handshake: the input register drains whenever the result register is free.
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q  <= in_i.operation;
      s1_tus_q <= in_i.time_us;
      s1_tms_q <= in_i.time_ms;
      s1_ch_q  <= in_i.channel;
    end
  end

  // Effective channel count, saturated to one through the channel maximum.
  always_comb begin
    n_eff = CntW'(cfg.chan_count);
    if (cfg.chan_count == '0) begin
      n_eff = CntW'(1);
    end else if (CntW'(cfg.chan_count) > CntW'(MaxChannels)) begin
      n_eff = CntW'(MaxChannels);
    end
  end

  assign width     = s1_tus_q - last_edge_q;
  assign is_sync   = width > TimeW'(cfg.sync_thr);
  assign timed_out = (s1_tms_q - last_frame_q) > TimeW'(cfg.timeout);

  always_comb begin
    if (width < TimeW'(cfg.min_width)) begin
      clamped = cfg.min_width;
    end else if (width > TimeW'(cfg.max_width)) begin
      clamped = cfg.max_width;
    end else begin
      clamped = width[ValW-1:0];
    end
  end

  // A channel pulse is stored only for channels below the effective count.
  assign hist_wr.en    = s1_fire && (s1_op_q == OpEdge) && !is_sync && (chan_cnt_q < n_eff);
  assign hist_wr.chan  = chan_cnt_q[ChanW-1:0];
  assign hist_wr.value = clamped;

  cdm_history u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (hist_wr),
    .rd_chan_i (s1_ch_q),
    .median_o  (median)
  );

  assign read_val = (CntW'(s1_ch_q) < n_eff) ? median : cfg.default_val;

  always_comb begin
    last_edge_d  = last_edge_q;
    last_frame_d = last_frame_q;
    chan_cnt_d   = chan_cnt_q;
    recv_d       = recv_q;
    if (s1_op_q == OpEdge) begin
      last_edge_d = s1_tus_q;
      if (is_sync) begin
        last_frame_d = s1_tms_q;
        chan_cnt_d   = '0;
        recv_d       = 1'b1;
      end else if (chan_cnt_q < CntW'(MaxChannels)) begin
        chan_cnt_d = chan_cnt_q + CntW'(1);
      end
    end else if (timed_out) begin
      recv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q  <= '0;
      last_frame_q <= '0;
      chan_cnt_q   <= '0;
      recv_q       <= 1'b0;
    end else if (s1_fire) begin
      last_edge_q  <= last_edge_d;
      last_frame_q <= last_frame_d;
      chan_cnt_q   <= chan_cnt_d;
      recv_q       <= recv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_value_q <= (s1_op_q == OpRead) ? read_val : '0;
      out_recv_q  <= recv_d;
      out_msf_q   <= s1_tms_q - last_frame_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.value          = out_value_q;
  assign out_o.receiving      = out_recv_q;
  assign out_o.ms_since_frame = out_msf_q;

endmodule

/* rtl/core/cdm_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the decoder and its bind to the top level.
module cdm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [cdm_pkg::ValW-1:0]    out_value_i,
  input logic                        out_recv_i,
  input logic [cdm_pkg::TimeW-1:0]   out_msf_i
);
  import cdm_pkg::*;

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> out_valid_i && $stable(out_value_i) && $stable(out_recv_i)
                  && $stable(out_msf_i))
    else $error("result word changed while stalled");

  // A result appears on an empty output once its input word has passed the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc, 2))
    else $error("result word without matching input word");

  // Only one word is buffered behind a stalled result.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && out_stall) ##1 out_stall |-> !in_ready_i)
    else $error("input accepted beyond buffer while stalled");

endmodule

bind cppm_decoder_median3 cdm_checker u_cdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value),
  .out_recv_i  (out_o.receiving),
  .out_msf_i   (out_o.ms_since_frame)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the CPPM decoder with median-of-three channel filtering.
module tb;
  import cdm_pkg::*;

  // One input word as the sender puts it on the input channel.
  typedef struct packed {
    op_e              op;
    logic [TimeW-1:0] t_us;
    logic [TimeW-1:0] t_ms;
    logic [ChanW-1:0] ch;
  } ppm_word_t;

  // One result word as the decoder returns it.
  typedef struct packed {
    logic [ValW-1:0]  value;
    logic             receiving;
    logic [TimeW-1:0] ms_since;
  } frame_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  cdm_in_if  in_if ();
  cdm_out_if out_if ();

  cppm_decoder_median3 u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Words waiting to be sent, and the decoded results still owed by the block.
  ppm_word_t     pending_words[$];
  frame_result_t predicted_results[$];

  // Idle rates of the sender and the receiver, in percent.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  bit          word_taken;

  // Shadow of the configuration registers and of the decoder state. The
  // shadow registers are updated at the moment each register write is issued,
  // which is safe because writes only happen while nothing is in flight.
  cfg_t            reg_mirror;
  logic [31:0]     last_edge_us;
  logic [31:0]     last_frame_ms;
  logic [CntW-1:0] pulse_idx;
  logic            rx_flag;
  logic [ValW-1:0] hist [MaxChannels][HistDepth];
  logic [1:0]      ring_pos [MaxChannels];

  // Cursors of the stimulus generator.
  logic [31:0] now_us;
  logic [31:0] now_ms;
  logic [31:0] frame_ms;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A channel count outside 1..MaxChannels is saturated into that range.
  function automatic int unsigned active_chans();
    if (reg_mirror.chan_count == 0) return 1;
    if (reg_mirror.chan_count > MaxChannels) return MaxChannels;
    return reg_mirror.chan_count;
  endfunction

  // Decode one accepted word against the shadow state and return the result
  // that the block must produce for it.
  function automatic frame_result_t decode_word(ppm_word_t w);
    frame_result_t r;
    logic [31:0]   gap;
    logic [15:0]   v;
    logic [15:0]   a;
    logic [15:0]   b;
    logic [15:0]   c;
    logic [15:0]   lo;
    logic [15:0]   hi;
    int unsigned   n;
    n = active_chans();
    r.value = '0;
    if (w.op == OpEdge) begin
      // The pulse width is the wrapping distance to the previous edge.
      gap = w.t_us - last_edge_us;
      last_edge_us = w.t_us;
      if (gap > {16'b0, reg_mirror.sync_thr}) begin
        last_frame_ms = w.t_ms;
        pulse_idx = '0;
        rx_flag = 1'b1;
      end else begin
        if (pulse_idx < n) begin
          // When min is set above max, widths below min take min and all others take max.
          if (gap < {16'b0, reg_mirror.min_width}) v = reg_mirror.min_width;
          else if (gap > {16'b0, reg_mirror.max_width}) v = reg_mirror.max_width;
          else v = gap[15:0];
          hist[pulse_idx][ring_pos[pulse_idx]] = v;
          ring_pos[pulse_idx] = (ring_pos[pulse_idx] == HistDepth - 1) ? 2'd0
                                                                      : ring_pos[pulse_idx] + 2'd1;
        end
        if (pulse_idx < MaxChannels) pulse_idx = pulse_idx + 1'b1;
      end
    end else begin
      // Only a read runs the timeout check.
      if (w.t_ms - last_frame_ms > {16'b0, reg_mirror.timeout}) rx_flag = 1'b0;
      if (w.ch < n) begin
        a = hist[w.ch][0];
        b = hist[w.ch][1];
        c = hist[w.ch][2];
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) r.value = lo;
        else if (c >= hi) r.value = hi;
        else r.value = c;
      end else begin
        r.value = reg_mirror.default_val;
      end
    end
    r.receiving = rx_flag;
    r.ms_since = w.t_ms - last_frame_ms;
    return r;
  endfunction

  // Input side: a word is taken at a rising edge with valid and ready high.
  // Output side: each result word is checked against the oldest prediction.
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    word_taken = 1'b0;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        word_taken = 1'b1;
        predicted_results.push_back(decode_word(pending_words.pop_front()));
      end
      if (out_if.valid && out_if.ready) begin
        got.value = out_if.value;
        got.receiving = out_if.receiving;
        got.ms_since = out_if.ms_since_frame;
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with no prediction: value %0d receiving %0d ms %0d",
                     $realtime, got.value, got.receiving, got.ms_since);
        end else begin
          want = predicted_results.pop_front();
          if (got.value !== want.value || got.receiving !== want.receiving ||
              got.ms_since !== want.ms_since) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: value %0d/%0d receiving %0d/%0d ms %0d/%0d (exp/got)",
                       $realtime, want.value, got.value, want.receiving, got.receiving,
                       want.ms_since, got.ms_since);
          end
        end
      end
    end
  end

  // Sender: a word on the channel stays put until it is taken; otherwise the
  // next pending word goes out unless the sender decides to idle this cycle.
  always @(negedge clk) begin
    if (rst_n && !(in_if.valid && !word_taken)) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.operation <= pending_words[0].op;
        in_if.time_us <= pending_words[0].t_us;
        in_if.time_ms <= pending_words[0].t_ms;
        in_if.channel <= pending_words[0].ch;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random at the current rate.
  always @(negedge clk) begin
    if (rst_n) out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      CfgChanCount: reg_mirror.chan_count = data[ChCfgW-1:0];
      CfgMinWidth:  reg_mirror.min_width = data;
      CfgMaxWidth:  reg_mirror.max_width = data;
      CfgDefault:   reg_mirror.default_val = data;
      CfgSyncThr:   reg_mirror.sync_thr = data;
      CfgTimeout:   reg_mirror.timeout = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(cfg_t s);
    write_reg(CfgChanCount, 16'(s.chan_count));
    write_reg(CfgMinWidth, s.min_width);
    write_reg(CfgMaxWidth, s.max_width);
    write_reg(CfgDefault, s.default_val);
    write_reg(CfgSyncThr, s.sync_thr);
    write_reg(CfgTimeout, s.timeout);
  endtask

  // Hold the sender back until every word has been sent and answered.
  task automatic drain();
    while (pending_words.size() != 0 || predicted_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_word(op_e op, logic [31:0] us, logic [31:0] ms, logic [3:0] ch);
    ppm_word_t w;
    w.op = op;
    w.t_us = us;
    w.t_ms = ms;
    w.ch = ch;
    pending_words.push_back(w);
  endtask

  // A read mostly comes a little later, sometimes right at the timeout
  // boundary of the last frame, sometimes much later.
  task automatic queue_read();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) now_ms = now_ms + $urandom_range(0, 20);
    else if (r < 8) now_ms = frame_ms + reg_mirror.timeout + $urandom_range(0, 1);
    else now_ms = now_ms + $urandom;
    queue_word(OpRead, $urandom, now_ms,
               $urandom_range(0, 1) ? 4'($urandom_range(0, 15))
                                    : 4'($urandom_range(0, active_chans())));
  endtask

  // Random traffic: mostly well-formed frames (sync gap, then one pulse per
  // channel with occasional short or long frames), reads mixed in, and a
  // small share of words at random times.
  task automatic queue_traffic(int unsigned count);
    int unsigned made;
    int unsigned n;
    int unsigned sync;
    int unsigned lo;
    int unsigned hi;
    int unsigned gap;
    int unsigned pulses;
    int unsigned r;
    made = 0;
    n = active_chans();
    sync = reg_mirror.sync_thr;
    lo = (reg_mirror.min_width < reg_mirror.max_width) ? reg_mirror.min_width
                                                       : reg_mirror.max_width;
    hi = (reg_mirror.min_width < reg_mirror.max_width) ? reg_mirror.max_width
                                                       : reg_mirror.min_width;
    lo = (lo > 300) ? lo - 300 : 0;
    hi = hi + 300;
    if (hi > sync) hi = sync;
    if (lo > hi) lo = hi;
    now_us = $urandom;
    now_ms = $urandom;
    frame_ms = now_ms;
    while (made < count) begin
      if ($urandom_range(0, 99) < 8) begin
        if ($urandom_range(0, 1)) begin
          now_us = $urandom;
          queue_word(OpEdge, now_us, $urandom, 4'($urandom_range(0, 15)));
        end else begin
          queue_word(OpRead, $urandom, $urandom, 4'($urandom_range(0, 15)));
        end
        made++;
      end else begin
        gap = ($urandom_range(0, 9) == 0) ? sync + 1 : sync + $urandom_range(1, 4000);
        now_us = now_us + gap;
        now_ms = now_ms + $urandom_range(0, 40);
        frame_ms = now_ms;
        queue_word(OpEdge, now_us, now_ms, 4'($urandom_range(0, 15)));
        made++;
        r = $urandom_range(0, 9);
        pulses = (r == 0) ? $urandom_range(n, 20) : (r == 1) ? $urandom_range(0, n) : n;
        for (int unsigned p = 0; p < pulses; p++) begin
          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sync) : $urandom_range(lo, hi);
          if ($urandom_range(0, 19) == 0) gap = sync;
          now_us = now_us + gap;
          now_ms = now_ms + $urandom_range(0, 2);
          queue_word(OpEdge, now_us, now_ms, 4'($urandom_range(0, 15)));
          made++;
          if ($urandom_range(0, 3) == 0) begin
            queue_read();
            made++;
          end
        end
        repeat ($urandom_range(1, 3)) begin
          queue_read();
          made++;
        end
      end
    end
  endtask

  // Register settings of the random phases: extremes first, then the
  // power-up values, min above max with a zero channel count, a count
  // beyond the channel limit, a zero sync threshold, and a mid setting.
  cfg_t settings [6];

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgChanCount;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.operation = OpEdge;
    in_if.time_us = '0;
    in_if.time_ms = '0;
    in_if.channel = '0;
    out_if.ready = 1'b0;
    mismatches = 0;
    send_idle_pct = 6;
    recv_idle_pct = 83;
    reg_mirror = '{RstChanCount, RstMinWidth, RstMaxWidth, RstDefault, RstSyncThr, RstTimeout};
    last_edge_us = '0;
    last_frame_ms = '0;
    pulse_idx = '0;
    rx_flag = 1'b0;
    for (int i = 0; i < MaxChannels; i++) begin
      ring_pos[i] = '0;
      for (int j = 0; j < HistDepth; j++) hist[i][j] = RstDefault;
    end
    settings[0] = '{5'd16, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0};
    settings[1] = '{5'd8, 16'd1000, 16'd2000, 16'd1500, 16'd3000, 16'd100};
    settings[2] = '{5'd0, 16'd2000, 16'd1000, 16'hFFFF, 16'd2500, 16'hFFFF};
    settings[3] = '{5'd31, 16'd900, 16'd2100, 16'd1234, 16'd4000, 16'd50};
    settings[4] = '{5'd1, 16'd1500, 16'd1500, 16'd7, 16'd0, 16'd1};
    settings[5] = '{5'd5, 16'd1100, 16'd1900, 16'd1500, 16'd3000, 16'd100};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words against the power-up settings (8 channels, clamp to
    // 1000..2000, sync above 3000, timeout 100).
    queue_word(OpRead, 32'd0, 32'd0, 4'd0);                    // untouched history
    queue_word(OpRead, 32'd0, 32'd5, 4'd15);                   // channel out of range
    queue_word(OpEdge, 32'd10000, 32'd10, 4'd3);               // sync gap
    queue_word(OpEdge, 32'd10500, 32'd11, 4'd0);               // short, clamped up
    queue_word(OpEdge, 32'd12000, 32'd11, 4'd0);               // in range
    queue_word(OpEdge, 32'd14900, 32'd12, 4'd0);               // long, clamped down
    queue_word(OpEdge, 32'd17900, 32'd12, 4'd0);               // gap equal to threshold
    queue_word(OpEdge, 32'd17900, 32'd12, 4'd0);               // zero width
    queue_word(OpRead, 32'd0, 32'd110, 4'd0);                  // exactly at the timeout
    queue_word(OpRead, 32'd0, 32'd111, 4'd7);                  // one past the timeout
    queue_word(OpRead, 32'd0, 32'd111, 4'd8);                  // first invalid channel
    queue_word(OpEdge, 32'hFFFF_FC00, 32'hFFFF_FFF0, 4'd0);    // sync near the wrap
    queue_word(OpEdge, 32'h0000_0200, 32'h0000_0005, 4'd0);    // pulse across the wrap
    queue_word(OpRead, 32'hFFFF_FFFF, 32'h0000_0010, 4'd0);    // elapsed ms across the wrap
    queue_word(OpRead, 32'd0, 32'hFFFF_FFFF, 4'd15);           // within the timeout across the wrap
    queue_word(OpEdge, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);   // all ones
    queue_word(OpEdge, 32'd0, 32'd0, 4'd0);                    // width of one
    queue_word(OpRead, 32'd0, 32'd0, 4'd1);
    drain();

    // Six random phases, two per idle pattern. Each phase writes every
    // register while the block is idle and waits for all results before the
    // next one, which also makes the sender pause with nothing in flight.
    for (int k = 0; k < 6; k++) begin
      send_idle_pct = (k < 2) ? 6 : (k < 4) ? 83 : 0;
      recv_idle_pct = (k < 2) ? 83 : (k < 4) ? 6 : 0;
      load_setting(settings[k]);
      queue_traffic(250);
      drain();
    end

    repeat (10) @(posedge clk);
    if (predicted_results.size() != 0) begin
      mismatches += predicted_results.size();
      $display("%0d predicted results never arrived", predicted_results.size());
    end
    if (mismatches == 0) begin
      $display("cppm_decoder_median3 verification clean");
    end else begin
      $display("cppm_decoder_median3 verification failed");
    end
    $finish;
  end

  // Guard against a hang: the slowest correct run takes well under a
  // millisecond of simulated time.
  initial begin
    #20ms;
    $display("cppm_decoder_median3 verification failed");
    $finish;
  end

endmodule

/* files.f */
rtl/core/cdm_pkg.sv
rtl/core/cdm_if.sv
rtl/core/cdm_cfg_regs.sv
rtl/core/cdm_history.sv
rtl/core/cppm_decoder_median3.sv
rtl/core/cdm_checker.sv
dv/tb.sv
